[sv/circle_pair_collision_response_core_defines.svh]
// assertion macros for the circle pair collision response core checker
// used by cpcr_checker.sv only; expects clk_i and rst_ni in scope
`ifndef CIRCLE_PAIR_COLLISION_RESPONSE_CORE_DEFINES_SVH
`define CIRCLE_PAIR_COLLISION_RESPONSE_CORE_DEFINES_SVH

// a stalled beat keeps its valid and its payload
`define CPCR_ASSERT_HOLD(lbl, vld, rdy, dat) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(dat))) \
    else $error("stalled beat changed");

// plain implication checked at every clock edge out of reset
`define CPCR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

[sv/cpcr_pkg.sv]
// shared constants, types and arithmetic helpers of the collision response core
// no dependencies; used by scoped names in every module but the checker
package cpcr_pkg;

  localparam int unsigned CompW    = 21;  // one Q11.10 component
  localparam int unsigned VecW     = 63;  // packed x,y,z
  localparam int unsigned EW       = 10;  // summed restitution, Q1.9
  localparam int unsigned DenW     = 26;
  localparam int unsigned ProdW    = 49;
  localparam int unsigned SqSteps  = 22;  // root digits of the squared distance
  localparam int unsigned VQuoW    = 24;  // velocity quotient bits
  localparam int unsigned PQuoW    = 11;  // push quotient bits
  localparam int unsigned StSqrt0  = 1;
  localparam int unsigned StVSet   = 1;
  localparam int unsigned StVDiv0  = 2;
  localparam int unsigned StPSet   = StSqrt0 + SqSteps;
  localparam int unsigned StPDiv0  = StPSet + 1;
  localparam int unsigned NumSt    = StPDiv0 + PQuoW;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QAw      = $clog2(QDepth);

  // item handed from the front part to the back part
  typedef struct packed {
    logic                   contact;
    logic                   dyn_a;
    logic                   dyn_b;
    logic [VecW-1:0]        pa;
    logic [VecW-1:0]        pb;
    logic [VecW-1:0]        va;
    logic [VecW-1:0]        vb;
    logic [2:0][21:0]       sub;
    logic [43:0]            d2;
    logic [EW-1:0]          e_sum;
    logic [27:0]            k1;
    logic [26:0]            k2;
    logic [DenW-1:0]        den;
  } front_item_t;

  // one back pipeline stage
  typedef struct packed {
    logic                   contact;
    logic                   dyn_a;
    logic                   dyn_b;
    logic [VecW-1:0]        pa;
    logic [VecW-1:0]        pb;
    logic [VecW-1:0]        va;
    logic [VecW-1:0]        vb;
    logic [2:0][21:0]       sub;
    logic [DenW-1:0]        den;
    logic [2:0][ProdW-1:0]  pr_a;
    logic [2:0][ProdW-1:0]  pr_b;
    logic [2:0][23:0]       ev;
    logic [2:0]             vneg;
    logic [2:0][ProdW-1:0]  vmag;
    logic [2:0][26:0]       vrem;
    logic [2:0][VQuoW-1:0]  vquo;
    logic [44:0]            sq_v;
    logic [44:0]            sq_r;
    logic [2:0]             pneg;
    logic [2:0][32:0]       pnum;
    logic [2:0][22:0]       prem;
    logic [2:0][PQuoW-1:0]  pquo;
  } back_t;

  function automatic logic signed [CompW-1:0] comp(input logic [VecW-1:0] p,
                                                   input int unsigned k);
    return p[CompW*k +: CompW];
  endfunction

  function automatic logic [CompW-1:0] sat21(input logic signed [25:0] v);
    if (v > 26'sd1048575) return 21'h0FFFFF;
    if (v < -26'sd1048576) return 21'h100000;
    return v[CompW-1:0];
  endfunction

  // divide by 512, nearest, ties away from zero
  function automatic logic signed [23:0] rnd512(input logic signed [32:0] x);
    logic [32:0] m;
    logic [32:0] q;
    m = x[32] ? 33'(-x) : 33'(x);
    q = (m + 33'd256) >> 9;
    return x[32] ? -24'(q) : 24'(q);
  endfunction

endpackage

[sv/circle_pair_collision_response_core.sv]
// top level of the sphere pair collision response core
// depends on cpcr_pkg, cpcr_front, cpcr_queue, cpcr_back
//
// channel   direction  beat contents
// s_axis    in         one sphere pair (positions, velocities, radii, masses, ...)
// m_axis    out        contact flag, new velocities and positions of the pair
//
// one pair accepted per cycle while s_axis_tready is high; a pair's result beat passes through
// two front stages, one queue slot, 35 back stages and the output register.
// the back latency is set by the 22 digit root and the 11 bit push divider after it;
// the 24 bit velocity divider runs beside the root.
// reset clears only stage and queue occupancy; there is no clearing pass.
// a stall on m_axis freezes the back stages; the front keeps filling the four entry
// queue and stops taking pairs once the queue and both front stages are full.
module circle_pair_collision_response_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // position_a, position_b, velocity_a, velocity_b, radius_a, radius_b,
  // mass_a, mass_b, restitution_a, restitution_b, dynamic_a, dynamic_b
  input  logic [343:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // contact, new_velocity_a, new_velocity_b, new_position_a, new_position_b, zero fill
  output logic [255:0] m_axis_tdata
);

  cpcr_pkg::front_item_t f_item, q_item;
  logic                  f_valid, f_ready, q_valid, q_ready;
  logic                  contact;
  logic [62:0]           nva, nvb, npa, npb;

  // front: contact test and coefficients
  cpcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pos_a_i     (s_axis_tdata[62:0]),
    .pos_b_i     (s_axis_tdata[125:63]),
    .vel_a_i     (s_axis_tdata[188:126]),
    .vel_b_i     (s_axis_tdata[251:189]),
    .radius_a_i  (s_axis_tdata[271:252]),
    .radius_b_i  (s_axis_tdata[291:272]),
    .mass_a_i    (s_axis_tdata[307:292]),
    .mass_b_i    (s_axis_tdata[323:308]),
    .rest_a_i    (s_axis_tdata[332:324]),
    .rest_b_i    (s_axis_tdata[341:333]),
    .dyn_a_i     (s_axis_tdata[342]),
    .dyn_b_i     (s_axis_tdata[343]),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_item_o  (f_item)
  );

  // queue between the two parts
  cpcr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  // back: velocities and push
  cpcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_item_i   (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .contact_o   (contact),
    .new_vel_a_o (nva),
    .new_vel_b_o (nvb),
    .new_pos_a_o (npa),
    .new_pos_b_o (npb)
  );

  // result packing
  assign m_axis_tdata = {3'b000, npb, npa, nvb, nva, contact};

endmodule

[sv/cpcr_front.sv]
// front part: contact test and response coefficients, two register stages
// depends on cpcr_pkg
module cpcr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [62:0]           pos_a_i,
  input  logic [62:0]           pos_b_i,
  input  logic [62:0]           vel_a_i,
  input  logic [62:0]           vel_b_i,
  input  logic [19:0]           radius_a_i,
  input  logic [19:0]           radius_b_i,
  input  logic [15:0]           mass_a_i,
  input  logic [15:0]           mass_b_i,
  input  logic [8:0]            rest_a_i,
  input  logic [8:0]            rest_b_i,
  input  logic                  dyn_a_i,
  input  logic                  dyn_b_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cpcr_pkg::front_item_t out_item_o
);

  typedef struct packed {
    logic             dyn_a;
    logic             dyn_b;
    logic [62:0]      pa;
    logic [62:0]      pb;
    logic [62:0]      va;
    logic [62:0]      vb;
    logic [2:0][21:0] sub;
    logic [2:0][42:0] sq;
    logic [41:0]      rs2;
    logic [15:0]      m1;
    logic [15:0]      m2;
    logic [25:0]      em2;
    logic [9:0]       e_sum;
  } f1_t;

  f1_t                   f1_q, f1_d;
  cpcr_pkg::front_item_t f2_q, f2_d;
  logic                  f1_v_q, f2_v_q;
  logic                  f1_en, f2_en;

  // elastic two-stage handshake
  assign f2_en       = !f2_v_q || out_ready_i;
  assign f1_en       = !f1_v_q || f2_en;
  assign in_ready_o  = f1_en;
  assign out_valid_o = f2_v_q;
  assign out_item_o  = f2_q;

  // stage one: differences, squares, effective masses
  always_comb begin
    logic signed [21:0] sd;
    logic signed [43:0] p44;
    logic [20:0]        rs;
    f1_d       = f1_q;
    f1_d.dyn_a = dyn_a_i;
    f1_d.dyn_b = dyn_b_i;
    f1_d.pa    = pos_a_i;
    f1_d.pb    = pos_b_i;
    f1_d.va    = vel_a_i;
    f1_d.vb    = vel_b_i;
    for (int unsigned k = 0; k < 3; k++) begin
      sd = 22'(cpcr_pkg::comp(pos_a_i, k)) - 22'(cpcr_pkg::comp(pos_b_i, k));
      p44 = sd * sd;
      f1_d.sub[k] = sd;
      f1_d.sq[k]  = p44[42:0];
    end
    rs          = 21'(radius_a_i) + 21'(radius_b_i);
    f1_d.rs2    = rs * rs;
    f1_d.m1     = !dyn_a_i ? 16'd256 : ((mass_a_i == 16'd0) ? 16'd1 : mass_a_i);
    f1_d.m2     = !dyn_b_i ? 16'd256 : ((mass_b_i == 16'd0) ? 16'd1 : mass_b_i);
    f1_d.e_sum  = 10'(rest_a_i) + 10'(rest_b_i);
    f1_d.em2    = 26'(f1_d.e_sum) * 26'(f1_d.m2);
  end

  // stage two: distance sum, contact compare, coefficients
  always_comb begin
    f2_d.dyn_a   = f1_q.dyn_a;
    f2_d.dyn_b   = f1_q.dyn_b;
    f2_d.pa      = f1_q.pa;
    f2_d.pb      = f1_q.pb;
    f2_d.va      = f1_q.va;
    f2_d.vb      = f1_q.vb;
    f2_d.sub     = f1_q.sub;
    f2_d.e_sum   = f1_q.e_sum;
    f2_d.d2      = 44'(f1_q.sq[0]) + 44'(f1_q.sq[1]) + 44'(f1_q.sq[2]);
    f2_d.contact = f2_d.d2 <= 44'(f1_q.rs2);
    f2_d.k1      = 28'({f1_q.m1, 9'b0}) - 28'(f1_q.em2);
    f2_d.k2      = 27'({f1_q.m2, 9'b0}) + 27'(f1_q.em2);
    f2_d.den     = 26'({(17'(f1_q.m1) + 17'(f1_q.m2)), 9'b0});
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else begin
      if (f1_en) f1_v_q <= in_valid_i;
      if (f2_en) f2_v_q <= f1_v_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (f1_en && in_valid_i) f1_q <= f1_d;
    if (f2_en && f1_v_q) f2_q <= f2_d;
  end

endmodule

[sv/cpcr_queue.sv]
// short queue between the front and back parts
// depends on cpcr_pkg
module cpcr_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  cpcr_pkg::front_item_t push_item_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output cpcr_pkg::front_item_t pop_item_o
);

  cpcr_pkg::front_item_t        mem_q [cpcr_pkg::QDepth];
  logic [cpcr_pkg::QAw-1:0]     wr_q, rd_q;
  logic [cpcr_pkg::QAw:0]       cnt_q;
  logic                         do_push, do_pop;

  assign push_ready_o = cnt_q != (cpcr_pkg::QAw + 1)'(cpcr_pkg::QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_item_i;
  end

endmodule

[sv/cpcr_back.sv]
// back part: response velocities and push, one shared pipeline of stages
// depends on cpcr_pkg
module cpcr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cpcr_pkg::front_item_t in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  contact_o,
  output logic [62:0]           new_vel_a_o,
  output logic [62:0]           new_vel_b_o,
  output logic [62:0]           new_pos_a_o,
  output logic [62:0]           new_pos_b_o
);

  localparam int unsigned Ns = cpcr_pkg::NumSt;

  cpcr_pkg::back_t st_q [Ns];
  cpcr_pkg::back_t st_d [Ns];
  logic [Ns-1:0]   st_v_q;
  logic            out_v_q, en;
  logic            contact_q;
  logic [62:0]     nva_q, nvb_q, npa_q, npb_q;
  logic            contact_d;
  logic [62:0]     nva_d, nvb_d, npa_d, npb_d;

  // whole pipeline moves when the output register is free
  assign en          = !out_v_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_v_q;
  assign contact_o   = contact_q;
  assign new_vel_a_o = nva_q;
  assign new_vel_b_o = nvb_q;
  assign new_pos_a_o = npa_q;
  assign new_pos_b_o = npb_q;

  // stage zero: products of the coefficients and restitution term
  always_comb begin
    logic signed [20:0] v1, v2;
    logic signed [21:0] dv;
    logic signed [48:0] p49a, p49b;
    logic signed [32:0] e33;
    st_d[0]         = st_q[0];
    st_d[0].contact = in_item_i.contact;
    st_d[0].dyn_a   = in_item_i.dyn_a;
    st_d[0].dyn_b   = in_item_i.dyn_b;
    st_d[0].pa      = in_item_i.pa;
    st_d[0].pb      = in_item_i.pb;
    st_d[0].va      = in_item_i.va;
    st_d[0].vb      = in_item_i.vb;
    st_d[0].sub     = in_item_i.sub;
    st_d[0].den     = in_item_i.den;
    st_d[0].sq_v    = 45'(in_item_i.d2);
    st_d[0].sq_r    = '0;
    for (int unsigned k = 0; k < 3; k++) begin
      v1 = in_item_i.dyn_a ? cpcr_pkg::comp(in_item_i.va, k) : '0;
      v2 = in_item_i.dyn_b ? cpcr_pkg::comp(in_item_i.vb, k) : '0;
      dv = 22'(v1) - 22'(v2);
      p49a = $signed(in_item_i.k1) * v1;
      p49b = $signed({1'b0, in_item_i.k2}) * v2;
      e33  = $signed({1'b0, in_item_i.e_sum}) * dv;
      st_d[0].pr_a[k] = p49a;
      st_d[0].pr_b[k] = p49b;
      st_d[0].ev[k]   = cpcr_pkg::rnd512(e33);
    end
  end

  // later stages: root digits, velocity quotient bits, push quotient bits
  always_comb begin
    logic [44:0]        t45;
    logic signed [48:0] n49;
    logic [48:0]        m49;
    logic [26:0]        r27;
    logic [22:0]        r23;
    logic [21:0]        root, asub;
    for (int unsigned s = 1; s < Ns; s++) begin
      st_d[s] = st_q[s-1];
      root    = st_q[s-1].sq_r[21:0];
      // one root digit per stage
      if (s >= cpcr_pkg::StSqrt0 && s < cpcr_pkg::StSqrt0 + cpcr_pkg::SqSteps) begin
        t45 = st_q[s-1].sq_r + (45'd1 << (42 - 2 * (s - cpcr_pkg::StSqrt0)));
        if (st_q[s-1].sq_v >= t45) begin
          st_d[s].sq_v = st_q[s-1].sq_v - t45;
          st_d[s].sq_r = (st_q[s-1].sq_r >> 1) +
                         (45'd1 << (42 - 2 * (s - cpcr_pkg::StSqrt0)));
        end else begin
          st_d[s].sq_r = st_q[s-1].sq_r >> 1;
        end
      end
      // velocity numerator, magnitude with half divisor for rounding
      if (s == cpcr_pkg::StVSet) begin
        for (int unsigned k = 0; k < 3; k++) begin
          n49 = $signed(st_q[s-1].pr_a[k]) + $signed(st_q[s-1].pr_b[k]);
          m49 = n49[48] ? 49'(-n49) : 49'(n49);
          st_d[s].vneg[k] = n49[48];
          st_d[s].vmag[k] = m49 + 49'(st_q[s-1].den >> 1);
          st_d[s].vrem[k] = 27'(st_d[s].vmag[k] >> cpcr_pkg::VQuoW);
          st_d[s].vquo[k] = '0;
        end
      end
      // one velocity quotient bit per stage
      if (s >= cpcr_pkg::StVDiv0 && s < cpcr_pkg::StVDiv0 + cpcr_pkg::VQuoW) begin
        for (int unsigned k = 0; k < 3; k++) begin
          r27 = {st_q[s-1].vrem[k][25:0],
                 st_q[s-1].vmag[k][cpcr_pkg::VQuoW - 1 - (s - cpcr_pkg::StVDiv0)]};
          if (r27 >= {1'b0, st_q[s-1].den}) begin
            st_d[s].vrem[k] = r27 - {1'b0, st_q[s-1].den};
            st_d[s].vquo[k] = {st_q[s-1].vquo[k][cpcr_pkg::VQuoW-2:0], 1'b1};
          end else begin
            st_d[s].vrem[k] = r27;
            st_d[s].vquo[k] = {st_q[s-1].vquo[k][cpcr_pkg::VQuoW-2:0], 1'b0};
          end
        end
      end
      // push numerator from the finished root
      if (s == cpcr_pkg::StPSet) begin
        for (int unsigned k = 0; k < 3; k++) begin
          asub = st_q[s-1].sub[k][21] ? 22'(-$signed(st_q[s-1].sub[k])) : st_q[s-1].sub[k];
          st_d[s].pneg[k] = st_q[s-1].sub[k][21];
          st_d[s].pnum[k] = 33'({asub, 10'b0}) + 33'(root >> 1);
          st_d[s].prem[k] = 23'(st_d[s].pnum[k] >> cpcr_pkg::PQuoW);
          st_d[s].pquo[k] = '0;
        end
      end
      // one push quotient bit per stage
      if (s >= cpcr_pkg::StPDiv0 && s < cpcr_pkg::StPDiv0 + cpcr_pkg::PQuoW) begin
        for (int unsigned k = 0; k < 3; k++) begin
          r23 = {st_q[s-1].prem[k][21:0],
                 st_q[s-1].pnum[k][cpcr_pkg::PQuoW - 1 - (s - cpcr_pkg::StPDiv0)]};
          if (r23 >= {1'b0, root}) begin
            st_d[s].prem[k] = r23 - {1'b0, root};
            st_d[s].pquo[k] = {st_q[s-1].pquo[k][cpcr_pkg::PQuoW-2:0], 1'b1};
          end else begin
            st_d[s].prem[k] = r23;
            st_d[s].pquo[k] = {st_q[s-1].pquo[k][cpcr_pkg::PQuoW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // signs, sums, saturation and pass-through selection
  always_comb begin
    cpcr_pkg::back_t    l;
    logic signed [24:0] nv1;
    logic signed [25:0] nv2;
    logic signed [11:0] u;
    logic signed [21:0] np1, np2;
    logic [62:0]        pv1, pv2, pp1, pp2;
    logic               dist_nz;
    l       = st_q[Ns-1];
    dist_nz = l.sq_r != '0;
    for (int unsigned k = 0; k < 3; k++) begin
      nv1 = l.vneg[k] ? -$signed({1'b0, l.vquo[k]}) : $signed({1'b0, l.vquo[k]});
      nv2 = 26'($signed(l.ev[k])) + 26'(nv1);
      u   = l.pneg[k] ? -$signed({1'b0, l.pquo[k]}) : $signed({1'b0, l.pquo[k]});
      np1 = 22'(cpcr_pkg::comp(l.pa, k)) + 22'(u);
      np2 = 22'(cpcr_pkg::comp(l.pb, k)) - 22'(u);
      pv1[21*k +: 21] = cpcr_pkg::sat21(26'(nv1));
      pv2[21*k +: 21] = cpcr_pkg::sat21(nv2);
      pp1[21*k +: 21] = cpcr_pkg::sat21(26'(np1));
      pp2[21*k +: 21] = cpcr_pkg::sat21(26'(np2));
    end
    contact_d = l.contact;
    nva_d = (l.contact && l.dyn_a) ? pv1 : l.va;
    nvb_d = (l.contact && l.dyn_b) ? pv2 : l.vb;
    npa_d = (l.contact && l.dyn_a && dist_nz) ? pp1 : l.pa;
    npb_d = (l.contact && l.dyn_b && dist_nz) ? pp2 : l.pb;
  end

  // stage and output valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q  <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      st_v_q  <= {st_v_q[Ns-2:0], in_valid_i};
      out_v_q <= st_v_q[Ns-1];
    end
  end

  // stage and output payloads
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int unsigned s = 0; s < Ns; s++) st_q[s] <= st_d[s];
      contact_q <= contact_d;
      nva_q     <= nva_d;
      nvb_q     <= nvb_d;
      npa_q     <= npa_d;
      npb_q     <= npb_d;
    end
  end

endmodule

[sv/cpcr_checker.sv]
// port level checks of the collision response core, bound to the top level
// depends on circle_pair_collision_response_core_defines.svh
`include "circle_pair_collision_response_core_defines.svh"

module cpcr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [343:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [255:0] m_axis_tdata
);

  logic in_beat;
  logic out_stall;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // result beat held while stalled
  `CPCR_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata)

  // zero fill above the last result field
  `CPCR_ASSERT_IMPL(a_out_fill, m_axis_tvalid, m_axis_tdata[255:253] == 3'b000)

  // input side only backs up after a result stall
  `CPCR_ASSERT_IMPL(a_ready_fall, $fell(s_axis_tready), $past(out_stall))

  // a stalled result never vanishes while input keeps flowing
  `CPCR_ASSERT_IMPL(a_out_keep, $past(out_stall) && $past(in_beat), m_axis_tvalid)

endmodule

bind circle_pair_collision_response_core cpcr_checker u_cpcr_checker (.*);
